// ===== design/xcl_pkg.sv =====
// ----------------------------------------------------------------------------
// xcl_pkg
// Types and constants for the XOR checksum line checker.
// ----------------------------------------------------------------------------
`default_nettype none

package xcl_pkg;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_COLON = 8'd58;

	typedef enum logic [1:0] {
		FAULT_NONE      = 2'd0,
		FAULT_NO_COLON  = 2'd1,
		FAULT_MALFORMED = 2'd2,
		FAULT_MISMATCH  = 2'd3
	} fault_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// result beat, last field (frame_ok) in the low bits
	typedef struct packed {
		logic [5:0] pad;
		logic [7:0] computed_checksum;
		logic [7:0] received_checksum;
		logic [6:0] payload_length;
		fault_t     fault;
		logic       frame_ok;
	} result_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'd48 && c <= 8'd57) begin
			h.val = 4'(c - 8'd48);
		end else if (c >= 8'd65 && c <= 8'd70) begin
			h.val = 4'(c - 8'd55);
		end else if (c >= 8'd97 && c <= 8'd102) begin
			h.val = 4'(c - 8'd87);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== design/xor_checksum_line_checker.sv =====
// ----------------------------------------------------------------------------
// xor_checksum_line_checker
// Checks the XOR checksum after the last colon of each received text line.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received character per beat. Carriage returns are
//   ignored, a line feed closes the line and yields one verdict beat on
//   m_axis; other characters are stored up to LINE_MAX per line, the rest
//   dropped. Every character beat gets through the input register and one
//   update of the line state; line feeds load the result register.
//   Throughput: one beat per cycle, except while a line feed is held.
//   Path: a verdict reaches m_axis from its line feed beat through the
//   input register, then the result register.
//   Stall: the result register holds a verdict until m_axis_tready. A
//   character beat keeps moving while a verdict waits; a line feed sitting
//   in the input register waits for the result register to free, and
//   s_axis_tready stays low until it moves on.
//   Reset: arst_n clears both valid flags and all line state, so the next
//   line starts empty.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checksum_line_checker #(
	parameter int LINE_MAX = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [0] frame_ok, [2:1] fault, [9:3] payload_length,
	// [17:10] received_checksum, [25:18] computed_checksum, [31:26] zero
	output logic [31:0] m_axis_tdata
);

	localparam int CW = $clog2(LINE_MAX + 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;

	logic [CW-1:0]    stored_count_q;
	logic [7:0]       running_xor_q;
	logic [7:0]       xor_before_colon_q;
	logic             colon_seen_q;
	logic [CW-1:0]    colon_position_q;
	logic [1:0]       tail_count_q;
	logic [7:0]       first_digit_q;
	logic [7:0]       second_digit_q;

	logic             out_valid_q;
	xcl_pkg::result_t out_q;

	logic             is_lf;
	logic             is_cr;
	logic             advance;
	logic             room;
	xcl_pkg::hex_t    hi;
	xcl_pkg::hex_t    lo;
	logic [CW-1:0]    plen;
	logic [7:0]       plen_wide;
	xcl_pkg::result_t verdict;

	assign is_lf   = (byte_s1 == xcl_pkg::CH_LF);
	assign is_cr   = (byte_s1 == xcl_pkg::CH_CR);
	assign advance = valid_s1 && (!is_lf || !out_valid_q || m_axis_tready);
	assign room    = (32'(stored_count_q) < 32'(LINE_MAX));

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// verdict from the current line state
	always_comb begin
		hi         = xcl_pkg::hex_decode(first_digit_q);
		lo         = xcl_pkg::hex_decode(second_digit_q);
		verdict    = '0;
		plen       = stored_count_q;
		verdict.computed_checksum = running_xor_q;
		if (!colon_seen_q) begin
			verdict.fault = xcl_pkg::FAULT_NO_COLON;
		end else begin
			plen = colon_position_q;
			verdict.computed_checksum = xor_before_colon_q;
			if (tail_count_q != 2'd2 || !hi.ok || !lo.ok) begin
				verdict.fault = xcl_pkg::FAULT_MALFORMED;
			end else begin
				verdict.received_checksum = {hi.val, lo.val};
				if ({hi.val, lo.val} == xor_before_colon_q) begin
					verdict.frame_ok = 1'b1;
					verdict.fault    = xcl_pkg::FAULT_NONE;
				end else begin
					verdict.fault = xcl_pkg::FAULT_MISMATCH;
				end
			end
		end
		plen_wide = 8'(plen);
		verdict.payload_length = (plen_wide > 8'd127) ? 7'd127 : plen_wide[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count_q     <= '0;
			running_xor_q      <= '0;
			xor_before_colon_q <= '0;
			colon_seen_q       <= 1'b0;
			colon_position_q   <= '0;
			tail_count_q       <= '0;
			first_digit_q      <= '0;
			second_digit_q     <= '0;
		end else if (advance && !is_cr) begin
			if (is_lf) begin
				stored_count_q     <= '0;
				running_xor_q      <= '0;
				xor_before_colon_q <= '0;
				colon_seen_q       <= 1'b0;
				colon_position_q   <= '0;
				tail_count_q       <= '0;
				first_digit_q      <= '0;
				second_digit_q     <= '0;
			end else if (room) begin
				if (byte_s1 == xcl_pkg::CH_COLON) begin
					colon_seen_q       <= 1'b1;
					colon_position_q   <= stored_count_q;
					xor_before_colon_q <= running_xor_q;
					tail_count_q       <= '0;
					first_digit_q      <= '0;
					second_digit_q     <= '0;
				end else if (colon_seen_q) begin
					if (tail_count_q == 2'd0) begin
						first_digit_q <= byte_s1;
					end
					if (tail_count_q == 2'd1) begin
						second_digit_q <= byte_s1;
					end
					if (tail_count_q != 2'd3) begin
						tail_count_q <= tail_count_q + 2'd1;
					end
				end
				running_xor_q  <= running_xor_q ^ byte_s1;
				stored_count_q <= stored_count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_lf) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_lf) begin
			out_q <= verdict;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
